// ===== hdl/blm_pkg.sv =====
// Shared types, constants and helpers for the Bayer quad luma modification block.
// Depends on nothing; every other file of the block imports it.
package blm_pkg;

	// Quad geometry and candidate count.
	localparam int PIX_N = 4;
	localparam int CAND_N = 8;

	// Register stages from the accepted beat to the registered luma.
	localparam int PIPE_DEPTH = 8;

	// Signed candidate quotient (luma minus 16) and its biased unsigned form.
	localparam int QW = 11;
	localparam int QUW = 10;
	localparam int QOFF = 512;

	// BT.601 coefficients in thousandths.
	localparam int MILLI_Y = 1164;
	localparam int MILLI_GB = 391;
	localparam int MILLI_GR = 813;
	localparam int MILLI_RR = 1596;
	localparam int MILLI_BB = 2018;

	localparam int CHROMA_MID = 128;
	localparam int LUMA_BIAS = 16;
	localparam int LUMA_MAX = 255;

	// Floor quotient of one pixel and whether the division came out even.
	typedef struct packed {
		logic signed [QW-1:0] q_floor;
		logic                 exact;
	} quot_t;

	// Coefficient scaled by 2^frac_bits, rounded to nearest.
	function automatic int fixed_coef(input int milli, input int frac_bits);
		return (milli * (1 << frac_bits) + 500) / 1000;
	endfunction

	// Adds the luma offset back and clamps to the 8-bit range.
	function automatic logic [7:0] clamp_luma(input logic signed [QW-1:0] q);
		logic signed [QW:0] y;
		y = QW'(q) + (QW + 1)'(LUMA_BIAS);
		if (y < 0) begin
			return 8'd0;
		end else if (y > (QW + 1)'(LUMA_MAX)) begin
			return 8'(LUMA_MAX);
		end else begin
			return y[7:0];
		end
	endfunction

endpackage

// ===== hdl/blm_div.sv =====
// Divides one pixel's biased numerator by the luma coefficient, floor and exactness.
// Two stages: reciprocal multiply, then one multiply-back and correction.
// Depends on blm_pkg.
module blm_div import blm_pkg::*; #(
	parameter int COEF_FRAC_BITS = 10
) (
	input  logic                        clk,
	input  logic [COEF_FRAC_BITS+10:0]  np,
	output quot_t                       quot_s3
);

	localparam int F = COEF_FRAC_BITS;
	localparam int NPW = F + 11;
	localparam int CY = fixed_coef(MILLI_Y, F);
	localparam int K = F + 11;
	localparam int RW = 11;
	localparam int RCP = (1 << K) / CY;
	localparam logic [RW-1:0] RCP_V = RW'(RCP);
	localparam logic [NPW-1:0] CY_V = NPW'(CY);

	logic [NPW+RW-1:0] prod_w;
	logic [QUW-1:0]    q0_s2;
	logic [NPW-1:0]    np_s2;
	logic [NPW-1:0]    qc_w;
	logic [NPW-1:0]    rem_w;
	logic [NPW-1:0]    rem_fix_w;
	logic              hi_w;
	logic [QUW-1:0]    qf_w;

	// The reciprocal estimate is never above the true quotient and at most one below it.
	assign prod_w = np * RCP_V;

	always_ff @(posedge clk) begin
		q0_s2 <= prod_w[K +: QUW];
		np_s2 <= np;
	end

	// Remainder check lifts the estimate by one where needed.
	assign qc_w = q0_s2 * CY_V;
	assign rem_w = np_s2 - qc_w;
	assign hi_w = (rem_w >= CY_V);
	assign rem_fix_w = hi_w ? (rem_w - CY_V) : rem_w;
	assign qf_w = q0_s2 + QUW'(hi_w);

	always_ff @(posedge clk) begin
		quot_s3.q_floor <= $signed({1'b0, qf_w}) - QW'(QOFF);
		quot_s3.exact <= (rem_fix_w == '0);
	end

endmodule

// ===== hdl/blm_lane.sv =====
// One candidate lane: ranking key of a candidate luma over the whole quad.
// The key is m*(2m - sum of numerators), with m the scaled candidate; it orders
// candidates exactly as the summed squared error does. Depends on blm_pkg.
module blm_lane import blm_pkg::*; #(
	parameter int COEF_FRAC_BITS = 10
) (
	input  logic                                clk,
	input  logic signed [QW-1:0]                q,
	input  logic signed [COEF_FRAC_BITS+11:0]   sumn,
	output logic signed [2*COEF_FRAC_BITS+23:0] key_s5,
	output logic signed [QW-1:0]                q_s5
);

	localparam int F = COEF_FRAC_BITS;
	localparam int MW = F + 11;
	localparam int TW = F + 13;
	localparam logic signed [MW-1:0] CY_M = MW'(fixed_coef(MILLI_Y, F));

	logic signed [MW-1:0] m_w;
	logic signed [TW-1:0] t_w;
	logic signed [MW-1:0] m_s4;
	logic signed [TW-1:0] t_s4;
	logic signed [QW-1:0] q_s4;

	// Scaled candidate and the linear factor of the key.
	assign m_w = CY_M * q;
	assign t_w = (TW'(m_w) <<< 1) - TW'(sumn);

	always_ff @(posedge clk) begin
		m_s4 <= m_w;
		t_s4 <= t_w;
		q_s4 <= q;
	end

	// Key product.
	always_ff @(posedge clk) begin
		key_s5 <= m_s4 * t_s4;
		q_s5 <= q_s4;
	end

endmodule

// ===== hdl/blm_merge.sv =====
// Registered minimum tree over the candidate keys, the earlier candidate winning ties,
// followed by the offset and clamp of the winner. Depends on blm_pkg.
module blm_merge import blm_pkg::*; #(
	parameter int KEY_W = 44
) (
	input  logic                    clk,
	input  logic signed [KEY_W-1:0] key [CAND_N],
	input  logic signed [QW-1:0]    q [CAND_N],
	output logic [7:0]              luma_s8
);

	logic signed [KEY_W-1:0] key_s6 [CAND_N/2];
	logic signed [QW-1:0]    q_s6 [CAND_N/2];
	logic signed [KEY_W-1:0] key_s7 [CAND_N/4];
	logic signed [QW-1:0]    q_s7 [CAND_N/4];

	// First level: the odd member takes a pair only when strictly lower.
	always_ff @(posedge clk) begin
		for (int i = 0; i < CAND_N / 2; i++) begin
			if (key[2*i+1] < key[2*i]) begin
				key_s6[i] <= key[2*i+1];
				q_s6[i] <= q[2*i+1];
			end else begin
				key_s6[i] <= key[2*i];
				q_s6[i] <= q[2*i];
			end
		end
	end

	// Second level.
	always_ff @(posedge clk) begin
		for (int i = 0; i < CAND_N / 4; i++) begin
			if (key_s6[2*i+1] < key_s6[2*i]) begin
				key_s7[i] <= key_s6[2*i+1];
				q_s7[i] <= q_s6[2*i+1];
			end else begin
				key_s7[i] <= key_s6[2*i];
				q_s7[i] <= q_s6[2*i];
			end
		end
	end

	// Final pick and clamp to the luma range.
	always_ff @(posedge clk) begin
		if (key_s7[1] < key_s7[0]) begin
			luma_s8 <= clamp_luma(q_s7[1]);
		end else begin
			luma_s8 <= clamp_luma(q_s7[0]);
		end
	end

endmodule

// ===== hdl/bayer_luma_modification.sv =====
// Bayer GRBG quad luma modification. The result strobe done is high in the same cycle
// that luma_out holds the result of its beat, and the result is taken at the edge that
// ends that cycle; the valid flag runs through a register for each datapath stage.
// Throughput: one quad per cycle; busy stays low, as every stage is a plain pipeline
// register and the eight candidate lanes run side by side.
// Reset (arst_n low) clears the valid pipeline only; datapath registers are not reset.
// Depends on blm_pkg, blm_div, blm_lane and blm_merge.
module bayer_luma_modification import blm_pkg::*; #(
	parameter int COEF_FRAC_BITS = 10
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [7:0] green_top,
	input  logic [7:0] red_sample,
	input  logic [7:0] blue_sample,
	input  logic [7:0] green_bottom,
	input  logic [7:0] chroma_blue,
	input  logic [7:0] chroma_red,
	output logic       done,
	output logic [7:0] luma_out
);

	localparam int F = COEF_FRAC_BITS;
	localparam int NPW = F + 11;
	localparam int WW = F + 14;
	localparam int SW = F + 12;
	localparam int KW = 2 * F + 24;
	localparam int CY = fixed_coef(MILLI_Y, F);

	localparam logic signed [WW-1:0] CGB_W = WW'(fixed_coef(MILLI_GB, F));
	localparam logic signed [WW-1:0] CGR_W = WW'(fixed_coef(MILLI_GR, F));
	localparam logic signed [WW-1:0] CRR_W = WW'(fixed_coef(MILLI_RR, F));
	localparam logic signed [WW-1:0] CBB_W = WW'(fixed_coef(MILLI_BB, F));
	localparam logic signed [WW-1:0] BIAS_W = WW'(QOFF * CY);
	localparam logic signed [WW-1:0] SUM_BIAS_W = WW'(PIX_N * QOFF * CY);

	logic signed [WW-1:0]  cb_w;
	logic signed [WW-1:0]  cr_w;
	logic signed [WW-1:0]  smp_w [PIX_N];
	logic signed [WW-1:0]  chroma_w [PIX_N];
	logic signed [WW-1:0]  np_w [PIX_N];
	logic [NPW-1:0]        np_s1 [PIX_N];
	logic signed [WW-1:0]  sumn_w;
	logic signed [SW-1:0]  sumn_s2;
	logic signed [SW-1:0]  sumn_s3;
	quot_t                 quot_s3 [PIX_N];
	logic signed [QW-1:0]  cand_q [CAND_N];
	logic signed [KW-1:0]  key_s5 [CAND_N];
	logic signed [QW-1:0]  q_s5 [CAND_N];
	logic [7:0]            luma_s8;
	logic [PIPE_DEPTH-1:0] vld_q;

	// Nothing ever holds the input side off.
	assign busy = 1'b0;

	// Centered chroma and the chroma part of each pixel's reconstruction.
	assign cb_w = $signed({{(WW-8){1'b0}}, chroma_blue}) - WW'(CHROMA_MID);
	assign cr_w = $signed({{(WW-8){1'b0}}, chroma_red}) - WW'(CHROMA_MID);
	assign smp_w[0] = $signed({{(WW-8){1'b0}}, green_top});
	assign smp_w[1] = $signed({{(WW-8){1'b0}}, red_sample});
	assign smp_w[2] = $signed({{(WW-8){1'b0}}, blue_sample});
	assign smp_w[3] = $signed({{(WW-8){1'b0}}, green_bottom});
	assign chroma_w[0] = -(CGB_W * cb_w) - (CGR_W * cr_w);
	assign chroma_w[1] = CRR_W * cr_w;
	assign chroma_w[2] = CBB_W * cb_w;
	assign chroma_w[3] = chroma_w[0];

	// Numerators, biased by a whole number of coefficients so they stay positive.
	always_comb begin
		for (int p = 0; p < PIX_N; p++) begin
			np_w[p] = (smp_w[p] <<< F) - chroma_w[p] + BIAS_W;
		end
	end

	always_ff @(posedge clk) begin
		for (int p = 0; p < PIX_N; p++) begin
			np_s1[p] <= np_w[p][NPW-1:0];
		end
	end

	// Sum of the unbiased numerators, aligned with the divider output.
	assign sumn_w = $signed({{(WW-NPW){1'b0}}, np_s1[0]})
		+ $signed({{(WW-NPW){1'b0}}, np_s1[1]})
		+ $signed({{(WW-NPW){1'b0}}, np_s1[2]})
		+ $signed({{(WW-NPW){1'b0}}, np_s1[3]})
		- SUM_BIAS_W;

	always_ff @(posedge clk) begin
		sumn_s2 <= sumn_w[SW-1:0];
		sumn_s3 <= sumn_s2;
	end

	// One divider per pixel, then floor and ceiling candidates for each.
	for (genvar p = 0; p < PIX_N; p++) begin : g_div
		blm_div #(
			.COEF_FRAC_BITS(COEF_FRAC_BITS)
		) u_div (
			.clk     (clk),
			.np      (np_s1[p]),
			.quot_s3 (quot_s3[p])
		);

		assign cand_q[2*p] = quot_s3[p].q_floor;
		assign cand_q[2*p+1] = quot_s3[p].q_floor
			+ $signed({{(QW-1){1'b0}}, ~quot_s3[p].exact});
	end

	// One cost lane per candidate.
	for (genvar k = 0; k < CAND_N; k++) begin : g_lane
		blm_lane #(
			.COEF_FRAC_BITS(COEF_FRAC_BITS)
		) u_lane (
			.clk    (clk),
			.q      (cand_q[k]),
			.sumn   (sumn_s3),
			.key_s5 (key_s5[k]),
			.q_s5   (q_s5[k])
		);
	end

	// Pick the lowest key.
	blm_merge #(
		.KEY_W(KW)
	) u_merge (
		.clk     (clk),
		.key     (key_s5),
		.q       (q_s5),
		.luma_s8 (luma_s8)
	);

	assign luma_out = luma_s8;

	// Valid flag follows each accepted beat down the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[PIPE_DEPTH-2:0], start & ~busy};
		end
	end

	assign done = vld_q[PIPE_DEPTH-1];

endmodule

// ===== hdl/blm_checker.sv =====
// Port-level checks of the luma modification block's timing, and their bind.
// Depends on blm_pkg and on the top level bayer_luma_modification.
module blm_checker import blm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	// The block never pushes back on the input side.
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised although the pipeline never stalls");

	// Every accepted beat yields a matching result strobe on done.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##PIPE_DEPTH done)
		else $error("accepted beat produced no result at the expected cycle");

	// No result strobe appears without a matching accepted beat.
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, PIPE_DEPTH))
		else $error("result strobe without a matching accepted beat");

endmodule

bind bayer_luma_modification blm_checker u_blm_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);
